FILE: hw/rtl/fur_pkg.sv
// Shared types, character constants and helpers for the framed UART ring buffers.
`default_nettype none

package fur_pkg;

   // Field widths of one request and one response
   localparam int MODE_W     = 2;
   localparam int BYTE_W     = 8;
   localparam int TX_FREE_W  = 10;
   localparam int RX_COUNT_W = 7;

   // Transmit store word: tag bit over a byte. A tagged word stands for a
   // close marker and holds the checksum that its two hex digits carry.
   localparam int TX_WORD_W  = BYTE_W + 1;

   // Framing characters
   localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h3E;  // '>'
   localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h3C;  // '<'
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [BYTE_W-1:0] CHAR_UPPER = 8'h41;  // 'A'
   localparam logic [3:0]        HEX_LIMIT  = 4'd9;
   localparam logic [BYTE_W-1:0] HEX_TEN    = 8'd10;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE    = 2'd0,  // software char write
      MODE_READ     = 2'd1,  // software read of a received byte
      MODE_TX_EMPTY = 2'd2,  // transmitter empty, send one byte
      MODE_RX_BYTE  = 2'd3   // byte received from the line
   } mode_type;

   // Suffix state of the transmit reader after a close marker
   typedef enum logic [1:0] {
      SFX_NONE = 2'd0,
      SFX_LOW  = 2'd1,
      SFX_HIGH = 2'd2
   } sfx_type;

   // Uppercase hex digit of one nibble
   function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
      logic [BYTE_W-1:0] n;
      n = {4'b0000, nib};
      return (nib <= HEX_LIMIT) ? (CHAR_ZERO + n) : (CHAR_UPPER + n - HEX_TEN);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fur_req_if.sv
// Request channel: valid/ready handshake carrying mode and data.
`default_nettype none

interface fur_req_if
   import fur_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] data;

   modport source (output valid, output mode, output data, input ready);
   modport sink   (input valid, input mode, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fur_rsp_if.sv
// Response channel: valid/ready handshake carrying one result per request.
`default_nettype none

interface fur_rsp_if
   import fur_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [BYTE_W-1:0]     out_byte;
   logic                  out_valid;
   logic                  refused;
   logic [TX_FREE_W-1:0]  tx_free;
   logic [RX_COUNT_W-1:0] rx_count;

   modport source (output valid, output out_byte, output out_valid, output refused,
                   output tx_free, output rx_count, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input refused,
                   input tx_free, input rx_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fur_ram.sv
// Generic single-write, single-read RAM with registered read (old data on collision).
`default_nettype none

module fur_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one word, read one word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/framed_uart_ring_buffers.sv
// Framed UART transmit and receive ring buffers with XOR checksum framing.
//
// Takes one request per clock cycle and returns exactly one response for it,
// held in an output register the cycle after acceptance; a new request is
// taken while that response waits as long as the response side is ready in
// the same cycle. Each request does one ring access: both rings sit in
// single-port-write RAMs whose registered read is fetched ahead at the next
// read index, with a bypass when the entry was written in the cycle before.
// A close marker takes three transmit slots but only one RAM word: the word
// is tagged and carries the checksum, and the reader produces the two hex
// digits from it on the following two sends. The stores need no clearing
// pass; requests are accepted from the first cycle after reset. Each ring
// keeps one slot free, so it holds at most depth minus one bytes.
`default_nettype none

module framed_uart_ring_buffers
   import fur_pkg::*;
#(
   parameter int TX_DEPTH = 1024,
   parameter int RX_DEPTH = 128
) (
   input  wire logic clock,
   input  wire logic reset,
   fur_req_if.sink   req_if,
   fur_rsp_if.source rsp_if
);

   localparam int TXA   = $clog2(TX_DEPTH);
   localparam int RXA   = $clog2(RX_DEPTH);
   localparam int TXF_W = (TXA > TX_FREE_W) ? TXA : TX_FREE_W;
   localparam int RXC_W = (RXA > RX_COUNT_W) ? RXA : RX_COUNT_W;

   // Ring state
   logic [TXA-1:0]    tx_head_ff, tx_head_in;
   logic [TXA-1:0]    tx_tail_ff, tx_tail_in;
   logic [TXA-1:0]    tx_used_ff, tx_used_in;
   logic [RXA-1:0]    rx_head_ff, rx_head_in;
   logic [RXA-1:0]    rx_tail_ff, rx_tail_in;
   logic [RXA-1:0]    rx_used_ff, rx_used_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   sfx_type           tx_sfx_ff, tx_sfx_in;
   logic [BYTE_W-1:0] tx_csum_ff, tx_csum_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                  rsp_bvalid_ff, rsp_bvalid_in;
   logic                  rsp_refused_ff, rsp_refused_in;
   logic [TX_FREE_W-1:0]  rsp_tx_free_ff, rsp_tx_free_in;
   logic [RX_COUNT_W-1:0] rsp_rx_count_ff, rsp_rx_count_in;

   // RAM ports and read bypass
   logic                 tx_we;
   logic [TX_WORD_W-1:0] tx_wdata, tx_rdata, tx_word;
   logic                 tx_byp_ff;
   logic [TX_WORD_W-1:0] tx_byp_data_ff;
   logic                 rx_we;
   logic [BYTE_W-1:0]    rx_rdata, rx_word;
   logic                 rx_byp_ff;
   logic [BYTE_W-1:0]    rx_byp_data_ff;

   logic           accept;
   mode_type       mode;
   logic [TXA-1:0] tx_room;
   logic [TXA:0]   tx_head_p3;
   logic [TXF_W-1:0] tx_room_ext;
   logic [RXC_W-1:0] rx_used_ext;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign mode         = mode_type'(req_if.mode);

   assign tx_room    = TXA'(TX_DEPTH - 1) - tx_used_ff;
   assign tx_head_p3 = {1'b0, tx_head_ff} + (TXA+1)'(3);

   // Take the bypassed word when the read entry was written last cycle
   assign tx_word = tx_byp_ff ? tx_byp_data_ff : tx_rdata;
   assign rx_word = rx_byp_ff ? rx_byp_data_ff : rx_rdata;

   // Work out the next state and the response of one request
   always_comb begin
      tx_head_in     = tx_head_ff;
      tx_tail_in     = tx_tail_ff;
      tx_used_in     = tx_used_ff;
      rx_head_in     = rx_head_ff;
      rx_tail_in     = rx_tail_ff;
      rx_used_in     = rx_used_ff;
      xor_in         = xor_ff;
      tx_sfx_in      = tx_sfx_ff;
      tx_csum_in     = tx_csum_ff;
      tx_we          = 1'b0;
      tx_wdata       = {1'b0, req_if.data};
      rx_we          = 1'b0;
      rsp_byte_in    = '0;
      rsp_bvalid_in  = 1'b0;
      rsp_refused_in = 1'b0;

      if (accept) begin
         unique case (mode)
            MODE_WRITE: begin
               if (req_if.data == CHAR_CLOSE) begin
                  if (tx_room < TXA'(3)) begin
                     rsp_refused_in = 1'b1;
                  end else begin
                     // Queue a tagged word standing for the marker and its digits
                     tx_we      = 1'b1;
                     tx_wdata   = {1'b1, xor_ff};
                     tx_used_in = tx_used_ff + TXA'(3);
                     if (tx_head_p3 >= (TXA+1)'(TX_DEPTH)) begin
                        tx_head_in = TXA'(tx_head_p3 - (TXA+1)'(TX_DEPTH));
                     end else begin
                        tx_head_in = TXA'(tx_head_p3);
                     end
                  end
               end else if (tx_room == '0) begin
                  rsp_refused_in = 1'b1;
               end else begin
                  tx_we      = 1'b1;
                  tx_used_in = tx_used_ff + TXA'(1);
                  tx_head_in = (tx_head_ff == TXA'(TX_DEPTH - 1)) ? '0
                                                                  : tx_head_ff + TXA'(1);
                  xor_in     = (req_if.data == CHAR_OPEN) ? '0 : (xor_ff ^ req_if.data);
               end
            end
            MODE_READ: begin
               if (rx_used_ff != '0) begin
                  rsp_byte_in   = rx_word;
                  rsp_bvalid_in = 1'b1;
                  rx_used_in    = rx_used_ff - RXA'(1);
                  rx_tail_in    = (rx_tail_ff == RXA'(RX_DEPTH - 1)) ? '0
                                                                     : rx_tail_ff + RXA'(1);
               end
            end
            MODE_TX_EMPTY: begin
               if (tx_used_ff != '0) begin
                  rsp_bvalid_in = 1'b1;
                  tx_used_in    = tx_used_ff - TXA'(1);
                  tx_tail_in    = (tx_tail_ff == TXA'(TX_DEPTH - 1)) ? '0
                                                                     : tx_tail_ff + TXA'(1);
                  case (tx_sfx_ff)
                     SFX_HIGH: begin
                        rsp_byte_in = hex_digit(tx_csum_ff[7:4]);
                        tx_sfx_in   = SFX_LOW;
                     end
                     SFX_LOW: begin
                        rsp_byte_in = hex_digit(tx_csum_ff[3:0]);
                        tx_sfx_in   = SFX_NONE;
                     end
                     default: begin
                        if (tx_word[TX_WORD_W-1]) begin
                           rsp_byte_in = CHAR_CLOSE;
                           tx_csum_in  = tx_word[BYTE_W-1:0];
                           tx_sfx_in   = SFX_HIGH;
                        end else begin
                           rsp_byte_in = tx_word[BYTE_W-1:0];
                        end
                     end
                  endcase
               end
            end
            MODE_RX_BYTE: begin
               if (rx_used_ff == RXA'(RX_DEPTH - 1)) begin
                  rsp_refused_in = 1'b1;
               end else begin
                  rx_we      = 1'b1;
                  rx_used_in = rx_used_ff + RXA'(1);
                  rx_head_in = (rx_head_ff == RXA'(RX_DEPTH - 1)) ? '0
                                                                  : rx_head_ff + RXA'(1);
               end
            end
            default: begin
               rsp_refused_in = 1'b0;
            end
         endcase
      end
   end

   // Fit the fill levels to the response field widths
   assign tx_room_ext     = TXF_W'(TXA'(TX_DEPTH - 1) - tx_used_in);
   assign rx_used_ext     = RXC_W'(rx_used_in);
   assign rsp_tx_free_in  = tx_room_ext[TX_FREE_W-1:0];
   assign rsp_rx_count_in = rx_used_ext[RX_COUNT_W-1:0];
   assign rsp_valid_in    = accept || (rsp_valid_ff && !rsp_if.ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_used_ff   <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_used_ff   <= '0;
         xor_ff       <= '0;
         tx_sfx_ff    <= SFX_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_used_ff   <= tx_used_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_used_ff   <= rx_used_in;
         xor_ff       <= xor_in;
         tx_sfx_ff    <= tx_sfx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold the response until taken, note read-after-write collisions
   always_ff @(posedge clock) begin
      tx_csum_ff     <= tx_csum_in;
      tx_byp_ff      <= tx_we && (tx_head_ff == tx_tail_in);
      tx_byp_data_ff <= tx_wdata;
      rx_byp_ff      <= rx_we && (rx_head_ff == rx_tail_in);
      rx_byp_data_ff <= req_if.data;
      if (accept) begin
         rsp_byte_ff     <= rsp_byte_in;
         rsp_bvalid_ff   <= rsp_bvalid_in;
         rsp_refused_ff  <= rsp_refused_in;
         rsp_tx_free_ff  <= rsp_tx_free_in;
         rsp_rx_count_ff <= rsp_rx_count_in;
      end
   end

   // Transmit store, read ahead at the next read index
   fur_ram #(
      .WIDTH (TX_WORD_W),
      .DEPTH (TX_DEPTH)
   ) u_tx_ram (
      .clock (clock),
      .we    (tx_we),
      .waddr (tx_head_ff),
      .wdata (tx_wdata),
      .raddr (tx_tail_in),
      .rdata (tx_rdata)
   );

   // Receive store, read ahead at the next read index
   fur_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RX_DEPTH)
   ) u_rx_ram (
      .clock (clock),
      .we    (rx_we),
      .waddr (rx_head_ff),
      .wdata (req_if.data),
      .raddr (rx_tail_in),
      .rdata (rx_rdata)
   );

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_byte  = rsp_byte_ff;
   assign rsp_if.out_valid = rsp_bvalid_ff;
   assign rsp_if.refused   = rsp_refused_ff;
   assign rsp_if.tx_free   = rsp_tx_free_ff;
   assign rsp_if.rx_count  = rsp_rx_count_ff;

endmodule

`default_nettype wire

FILE: sim/tb_framed_uart_ring_buffers.sv
// Self-checking testbench for the framed UART ring buffers: directed and random requests.
module tb_framed_uart_ring_buffers
   import fur_pkg::*;
();

   localparam int TX_SLOTS     = 1024;
   localparam int RX_SLOTS     = 128;
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [BYTE_W-1:0]     out_byte;
      logic                  out_valid;
      logic                  refused;
      logic [TX_FREE_W-1:0]  tx_free;
      logic [RX_COUNT_W-1:0] rx_count;
   } reply_type;

   // Mirror of both rings and the checksum; one expected reply per request
   class ring_scoreboard;
      logic [BYTE_W-1:0] tx_ring [TX_SLOTS];
      logic [BYTE_W-1:0] rx_ring [RX_SLOTS];
      int                tx_wr, tx_rd, rx_wr, rx_rd;
      logic [BYTE_W-1:0] checksum;
      reply_type         expected_replies [$];
      int                requests, checked, mismatches, unexpected, reported;
      int                tx_refusals, rx_drops, empty_answers, frames_closed;

      function new();
         tx_wr = 0;
         tx_rd = 0;
         rx_wr = 0;
         rx_rd = 0;
         checksum = '0;
      endfunction

      function int tx_used();
         return (tx_wr - tx_rd + TX_SLOTS) % TX_SLOTS;
      endfunction

      function int tx_room();
         return TX_SLOTS - 1 - tx_used();
      endfunction

      function int rx_used();
         return (rx_wr - rx_rd + RX_SLOTS) % RX_SLOTS;
      endfunction

      function void tx_push(logic [BYTE_W-1:0] b);
         tx_ring[tx_wr] = b;
         tx_wr = (tx_wr + 1) % TX_SLOTS;
      endfunction

      // Uppercase hex character of one checksum nibble
      function logic [BYTE_W-1:0] hex_char(logic [3:0] nib);
         if (nib < 4'd10) return CHAR_ZERO + BYTE_W'(nib);
         return CHAR_UPPER + BYTE_W'(nib) - BYTE_W'(10);
      endfunction

      // Work out the reply of one accepted request and advance the mirror
      function void note_request(mode_type m, logic [BYTE_W-1:0] d);
         reply_type r;
         int        need;
         r = '0;
         case (m)
            MODE_WRITE: begin
               need = (d == CHAR_CLOSE) ? 3 : 1;
               if (tx_room() < need) begin
                  r.refused = 1'b1;
                  tx_refusals++;
               end else begin
                  tx_push(d);
                  if (d == CHAR_OPEN) begin
                     checksum = '0;
                  end else if (d == CHAR_CLOSE) begin
                     tx_push(hex_char(checksum[7:4]));
                     tx_push(hex_char(checksum[3:0]));
                     frames_closed++;
                  end else begin
                     checksum = checksum ^ d;
                  end
               end
            end
            MODE_READ: begin
               if (rx_used() != 0) begin
                  r.out_byte  = rx_ring[rx_rd];
                  r.out_valid = 1'b1;
                  rx_rd = (rx_rd + 1) % RX_SLOTS;
               end else begin
                  empty_answers++;
               end
            end
            MODE_TX_EMPTY: begin
               if (tx_used() != 0) begin
                  r.out_byte  = tx_ring[tx_rd];
                  r.out_valid = 1'b1;
                  tx_rd = (tx_rd + 1) % TX_SLOTS;
               end else begin
                  empty_answers++;
               end
            end
            default: begin
               if ((rx_wr + 1) % RX_SLOTS == rx_rd) begin
                  r.refused = 1'b1;
                  rx_drops++;
               end else begin
                  rx_ring[rx_wr] = d;
                  rx_wr = (rx_wr + 1) % RX_SLOTS;
               end
            end
         endcase
         r.tx_free  = TX_FREE_W'(tx_room());
         r.rx_count = RX_COUNT_W'(rx_used());
         expected_replies.push_back(r);
         requests++;
      endfunction

      // Compare one reply with the oldest expectation, field by field
      function void check_reply(logic [BYTE_W-1:0] b, logic v, logic rf,
                                logic [TX_FREE_W-1:0] fr, logic [RX_COUNT_W-1:0] cnt);
         reply_type   want;
         logic [31:0] want_f [5];
         logic [31:0] got_f [5];
         string       label [5];
         label = '{"out_byte", "out_valid", "refused", "tx_free", "rx_count"};
         if (expected_replies.size() == 0) begin
            unexpected++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: reply with none outstanding: byte %0h valid %0b", b, v);
            end
            return;
         end
         want = expected_replies.pop_front();
         checked++;
         want_f = '{want.out_byte, want.out_valid, want.refused, want.tx_free, want.rx_count};
         got_f  = '{b, v, rf, fr, cnt};
         for (int i = 0; i < 5; i++) begin
            if (want_f[i] !== got_f[i]) begin
               mismatches++;
               if (reported < 10) begin
                  reported++;
                  $display("ERROR: reply %0d field %s expected %0h got %0h",
                           checked, label[i], want_f[i], got_f[i]);
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   fur_req_if req_if ();
   fur_rsp_if rsp_if ();

   framed_uart_ring_buffers #(
      .TX_DEPTH (TX_SLOTS),
      .RX_DEPTH (RX_SLOTS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   ring_scoreboard sb = new();

   bit calm;
   bit long_hold_pending;
   int long_holds;
   bit in_frame;
   int body_left;
   int idle_cycles;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   // Next software char: mostly well-formed frames, some stray chars
   function automatic logic [BYTE_W-1:0] next_char();
      if (!in_frame) begin
         if ($urandom_range(0, 9) == 0) return BYTE_W'($urandom_range(0, 255));
         in_frame  = 1'b1;
         body_left = $urandom_range(0, 12);
         return CHAR_OPEN;
      end
      if (body_left > 0) begin
         body_left--;
         return BYTE_W'($urandom_range(0, 255));
      end
      in_frame = 1'b0;
      return CHAR_CLOSE;
   endfunction

   // Offer one request and hold it until accepted; call just after a rising edge
   task automatic offer(input mode_type m, input logic [BYTE_W-1:0] d);
      int gap;
      gap = (!calm && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode  <= m;
      req_if.data  <= d;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid and wait until every expected reply has come
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_replies.size() != 0);
   endtask

   // Random requests with the given mode weights; the rest are received bytes
   task automatic run_phase(input int count, input int w_write, input int w_read,
                            input int w_send, input bit steady);
      int       r;
      mode_type m;
      for (int i = 0; i < count; i++) begin
         if (steady) calm = 1'b1;
         else if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < w_write) m = MODE_WRITE;
         else if (r < w_write + w_read) m = MODE_READ;
         else if (r < w_write + w_read + w_send) m = MODE_TX_EMPTY;
         else m = MODE_RX_BYTE;
         if (m == MODE_WRITE) offer(m, next_char());
         else offer(m, BYTE_W'($urandom_range(0, 255)));
      end
      calm = 1'b0;
   endtask

   // Response side: random stalls, quiet stretches and one long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            long_holds++;
            stall_left = LONG_HOLD;
         end else if (!calm && $urandom_range(0, 99) < 12) begin
            stall_left = pick_gap();
         end
         rsp_if.ready <= (stall_left == 0) && !reset;
      end
   end

   // Watch both channels: check replies first, then note the new request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_reply(rsp_if.out_byte, rsp_if.out_valid, rsp_if.refused,
                           rsp_if.tx_free, rsp_if.rx_count);
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_request(mode_type'(req_if.mode), req_if.data);
         end
      end
   end

   // Stop a run in which nothing moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      int failures;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.mode  <= MODE_WRITE;
      req_if.data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty rings, framing with digit and letter checksums, line bytes
      offer(MODE_TX_EMPTY, 8'h00);
      offer(MODE_READ, 8'hFF);
      offer(MODE_WRITE, CHAR_CLOSE);
      offer(MODE_WRITE, CHAR_OPEN);
      offer(MODE_WRITE, 8'h00);
      offer(MODE_WRITE, 8'hFF);
      offer(MODE_WRITE, 8'h41);
      offer(MODE_WRITE, CHAR_CLOSE);
      offer(MODE_WRITE, CHAR_OPEN);
      offer(MODE_WRITE, 8'h12);
      offer(MODE_WRITE, CHAR_CLOSE);
      offer(MODE_RX_BYTE, 8'h00);
      offer(MODE_RX_BYTE, 8'hFF);
      offer(MODE_RX_BYTE, 8'h5A);
      offer(MODE_READ, 8'h00);
      offer(MODE_READ, 8'hA5);
      offer(MODE_READ, 8'h00);
      offer(MODE_READ, 8'hFF);
      for (int i = 0; i < 6; i++) offer(MODE_TX_EMPTY, 8'hFF);
      wait_drained();

      // Hold the response side off while requests keep coming
      long_hold_pending = 1'b1;
      run_phase(60, 30, 10, 15, 1'b1);
      wait_drained();

      // Mixed traffic, then fill both rings, then work near full
      run_phase(200, 30, 10, 15, 1'b0);
      wait_drained();
      run_phase(950, 88, 0, 0, 1'b0);
      wait_drained();
      run_phase(250, 35, 25, 30, 1'b0);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      failures = sb.mismatches + sb.unexpected + sb.expected_replies.size();
      $display("Run: %0d requests, %0d replies checked, %0d frames closed, %0d long hold-offs",
               sb.requests, sb.checked, sb.frames_closed, long_holds);
      $display("Run: %0d writes refused, %0d line bytes dropped, %0d empty reads or sends",
               sb.tx_refusals, sb.rx_drops, sb.empty_answers);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/fur_pkg.sv
hw/rtl/fur_req_if.sv
hw/rtl/fur_rsp_if.sv
hw/rtl/fur_ram.sv
hw/rtl/framed_uart_ring_buffers.sv
sim/tb_framed_uart_ring_buffers.sv
